@@ hw/rtl/rlkd_pkg.sv @@
// rlkd_pkg: shared types, codes and reset values of the resistor ladder key decoder
// no dependencies; imported by every rlkd module and the top level

package rlkd_pkg;

    // field widths fixed by the interface
    localparam int RAW_W     = 12;
    localparam int MV_W      = 12;
    localparam int SAMPLES_W = 10;
    localparam int CODE_W    = 3;
    localparam int IDX_W     = 3;
    localparam int DATA_W    = 12;

    // conversion constants: mv = floor(raw * MV_FULL / RAW_FULL)
    localparam int MV_FULL  = 2500;
    localparam int RAW_FULL = 4095;
    localparam int PROD_W   = 24;

    typedef logic [CODE_W-1:0]    code_t;
    typedef logic [MV_W-1:0]      mv_t;
    typedef logic [SAMPLES_W-1:0] samples_t;

    // key event codes
    localparam code_t EV_NONE      = 3'd0;
    localparam code_t EV_DOWN      = 3'd1;
    localparam code_t EV_UP        = 3'd2;
    localparam code_t EV_LONG_DOWN = 3'd3;
    localparam code_t EV_LONG_UP   = 3'd4;

    // ladder key codes
    localparam code_t KEY_NONE     = 3'd0;
    localparam code_t KEY_RECORD   = 3'd1;
    localparam code_t KEY_NEXT     = 3'd2;
    localparam code_t KEY_PREVIOUS = 3'd3;
    localparam code_t KEY_PLAY     = 3'd4;

    // register indexes
    localparam logic [IDX_W-1:0] REG_RELEASE_LEVEL = 3'd0;
    localparam logic [IDX_W-1:0] REG_BAND_ONE_TOP  = 3'd1;
    localparam logic [IDX_W-1:0] REG_BAND_TWO_TOP  = 3'd2;
    localparam logic [IDX_W-1:0] REG_BAND_THREE_TOP = 3'd3;
    localparam logic [IDX_W-1:0] REG_BAND_FOUR_TOP = 3'd4;
    localparam logic [IDX_W-1:0] REG_DEBOUNCE      = 3'd5;
    localparam logic [IDX_W-1:0] REG_LONG_PRESS    = 3'd6;

    // register reset values
    localparam mv_t      RST_RELEASE_LEVEL  = 12'd500;
    localparam mv_t      RST_BAND_ONE_TOP   = 12'd900;
    localparam mv_t      RST_BAND_TWO_TOP   = 12'd1150;
    localparam mv_t      RST_BAND_THREE_TOP = 12'd1500;
    localparam mv_t      RST_BAND_FOUR_TOP  = 12'd1900;
    localparam samples_t RST_DEBOUNCE       = 10'd2;
    localparam samples_t RST_LONG_PRESS     = 10'd40;

    typedef struct packed {
        mv_t      release_level;
        mv_t      band_one_top;
        mv_t      band_two_top;
        mv_t      band_three_top;
        mv_t      band_four_top;
        samples_t debounce_samples;
        samples_t long_press_samples;
    } cfg_t;

endpackage

@@ hw/rtl/rlkd_cfg_regs.sv @@
// rlkd_cfg_regs: configuration register file of the key decoder
// depends on rlkd_pkg

module rlkd_cfg_regs
    import rlkd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RELEASE_LEVEL:  cfg_next.release_level = cfg_data;
                REG_BAND_ONE_TOP:   cfg_next.band_one_top = cfg_data;
                REG_BAND_TWO_TOP:   cfg_next.band_two_top = cfg_data;
                REG_BAND_THREE_TOP: cfg_next.band_three_top = cfg_data;
                REG_BAND_FOUR_TOP:  cfg_next.band_four_top = cfg_data;
                REG_DEBOUNCE:       cfg_next.debounce_samples = cfg_data[SAMPLES_W-1:0];
                REG_LONG_PRESS:     cfg_next.long_press_samples = cfg_data[SAMPLES_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.release_level      <= RST_RELEASE_LEVEL;
            cfg_reg.band_one_top       <= RST_BAND_ONE_TOP;
            cfg_reg.band_two_top       <= RST_BAND_TWO_TOP;
            cfg_reg.band_three_top     <= RST_BAND_THREE_TOP;
            cfg_reg.band_four_top      <= RST_BAND_FOUR_TOP;
            cfg_reg.debounce_samples   <= RST_DEBOUNCE;
            cfg_reg.long_press_samples <= RST_LONG_PRESS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hw/rtl/rlkd_mv_conv.sv @@
// rlkd_mv_conv: raw converter code to millivolts, floor(raw * 2500 / 4095)
// depends on rlkd_pkg

module rlkd_mv_conv
    import rlkd_pkg::*;
(
    input  logic [RAW_W-1:0] raw,
    output mv_t              mv
);

    logic [PROD_W-1:0] prod;
    logic [MV_W-1:0]   q0;
    logic [MV_W:0]     rem;

    // divide by 2^12-1: q0 = prod >> 12 is low by at most one, and the
    // remainder prod - q0*4095 folds to low bits plus q0
    always_comb
    begin
        prod = PROD_W'(raw) * PROD_W'(MV_FULL);
        q0   = prod[PROD_W-1:RAW_W];
        rem  = {1'b0, prod[RAW_W-1:0]} + {1'b0, q0};
        if (rem >= (MV_W+1)'(RAW_FULL))
            mv = q0 + 12'd1;
        else
            mv = q0;
    end

endmodule

@@ hw/rtl/rlkd_band_match.sv @@
// rlkd_band_match: picks the ladder key whose millivolt band holds the sample
// depends on rlkd_pkg

module rlkd_band_match
    import rlkd_pkg::*;
(
    input  mv_t   mv,
    input  cfg_t  cfg,
    output code_t key
);

    mv_t bounds [5];

    always_comb
    begin
        bounds[0] = cfg.release_level;
        bounds[1] = cfg.band_one_top;
        bounds[2] = cfg.band_two_top;
        bounds[3] = cfg.band_three_top;
        bounds[4] = cfg.band_four_top;
        key = KEY_NONE;
        // walk from the top band down so the lowest matching band wins
        for (int k = 3; k >= 0; k--)
        begin
            if (mv > bounds[k] && mv <= bounds[k+1])
                key = CODE_W'(k + 1);
        end
    end

endmodule

@@ hw/rtl/rlkd_key_tracker.sv @@
// rlkd_key_tracker: press state, held key and hold counter; produces the key event
// depends on rlkd_pkg and rlkd_band_match

module rlkd_key_tracker
    import rlkd_pkg::*;
#(
    parameter int COUNT_BITS = 11
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step,
    input  mv_t   mv,
    input  cfg_t  cfg,
    output code_t key_event,
    output code_t current_key
);

    localparam int CMP_W = (COUNT_BITS > SAMPLES_W) ? COUNT_BITS : SAMPLES_W;

    logic                  key_down_reg;
    logic                  key_down_next;
    code_t                 held_key_reg;
    code_t                 held_key_next;
    logic [COUNT_BITS-1:0] hold_count_reg;
    logic [COUNT_BITS-1:0] hold_count_next;

    code_t                 key;
    code_t                 base_key;
    logic [COUNT_BITS-1:0] base_count;
    logic [COUNT_BITS-1:0] inc_count;
    logic [SAMPLES_W:0]    long_plus;
    logic [CMP_W-1:0]      long_ext;
    logic [CMP_W-1:0]      deb_ext;
    logic [CMP_W-1:0]      held_ext;
    logic [CMP_W-1:0]      inc_ext;

    rlkd_band_match u_band_match
    (
        .mv  (mv),
        .cfg (cfg),
        .key (key)
    );

    always_comb
    begin
        long_ext  = CMP_W'(cfg.long_press_samples);
        deb_ext   = CMP_W'(cfg.debounce_samples);
        held_ext  = CMP_W'(hold_count_reg);
        long_plus = {1'b0, cfg.long_press_samples} + (SAMPLES_W+1)'(1);

        // a new press starts from a cleared count
        base_key   = held_key_reg;
        base_count = hold_count_reg;
        if (!key_down_reg)
        begin
            base_count = '0;
            if (key != KEY_NONE)
                base_key = key;
        end
        inc_count = base_count + COUNT_BITS'(1);
        inc_ext   = CMP_W'(inc_count);

        key_event       = EV_NONE;
        key_down_next   = key_down_reg;
        held_key_next   = held_key_reg;
        hold_count_next = hold_count_reg;

        if (mv <= cfg.release_level)
        begin
            // release keeps key and count, reports on a falling press only
            if (key_down_reg)
            begin
                key_event     = (held_ext < long_ext) ? EV_UP : EV_LONG_UP;
                key_down_next = 1'b0;
            end
        end
        else
        begin
            key_down_next = 1'b1;
            if (base_key != key)
            begin
                hold_count_next = '0;
                held_key_next   = key;
            end
            else
            begin
                held_key_next   = base_key;
                hold_count_next = inc_count;
                if (inc_ext == long_ext)
                    key_event = EV_LONG_DOWN;
                else if (inc_ext == deb_ext)
                    key_event = EV_DOWN;
                else if (inc_ext > long_ext)
                    hold_count_next = COUNT_BITS'(long_plus);
            end
        end

        current_key = held_key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_down_reg   <= 1'b0;
            held_key_reg   <= KEY_NONE;
            hold_count_reg <= '0;
        end
        else if (step)
        begin
            key_down_reg   <= key_down_next;
            held_key_reg   <= held_key_next;
            hold_count_reg <= hold_count_next;
        end
    end

endmodule

@@ hw/rtl/resistor_ladder_key_decoder.sv @@
// resistor_ladder_key_decoder: top level of the ladder keypad decoder
// depends on rlkd_pkg, rlkd_cfg_regs, rlkd_mv_conv, rlkd_key_tracker
//
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------
//  sample  | sample_valid/sample_stall | adc_sample[11:0]
//  result  | result_valid/result_stall | key_event[2:0], current_key[2:0]
//  cfg     | cfg_valid/cfg_ready       | cfg_index[2:0], cfg_data[11:0]
//
// one item per cycle sustained while result_stall stays low; an accepted sample passes the input
// register, then conversion, band match and counter update into the result register
// reset clears the valid flags, key state and restores the register defaults
// a stalled result holds the input register; one waiting sample plus one
// waiting result, and a new sample is taken in the same cycle the result leaves
// cfg_ready is always high; writes land in the next cycle

module resistor_ladder_key_decoder
    import rlkd_pkg::*;
#(
    parameter int COUNT_BITS = 11
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              sample_valid,
    output logic              sample_stall,
    input  logic [RAW_W-1:0]  adc_sample,

    output logic              result_valid,
    input  logic              result_stall,
    output code_t             key_event,
    output code_t             current_key,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0] cfg_data
);

    cfg_t cfg;

    // input register
    logic             in_valid_reg;
    logic             in_valid_next;
    logic [RAW_W-1:0] sample_reg;

    // result register
    logic             res_valid_reg;
    logic             res_valid_next;
    code_t            event_reg;
    code_t            key_reg;

    logic  advance;
    logic  accept;
    mv_t   mv;
    code_t step_event;
    code_t step_key;

    rlkd_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rlkd_mv_conv u_mv_conv
    (
        .raw (sample_reg),
        .mv  (mv)
    );

    rlkd_key_tracker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_key_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .mv          (mv),
        .cfg         (cfg),
        .key_event   (step_event),
        .current_key (step_key)
    );

    // an item moves on when the result slot is free or being emptied
    assign advance      = in_valid_reg && (!res_valid_reg || !result_stall);
    assign sample_stall = in_valid_reg && !advance;
    assign accept       = sample_valid && !sample_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = 1'b1;
        else if (!result_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            sample_reg <= adc_sample;
        if (advance)
        begin
            event_reg <= step_event;
            key_reg   <= step_key;
        end
    end

    assign result_valid = res_valid_reg;
    assign key_event    = event_reg;
    assign current_key  = key_reg;

endmodule

@@ tb/rlkd_checker.sv @@
// rlkd_checker: watches the sample, result and register channels of the ladder key decoder,
// predicts every result from its own copy of the key state and compares in order
// depends on rlkd_pkg for widths, event codes, key codes and register indexes

module rlkd_checker
    import rlkd_pkg::*;
#(
    parameter int COUNT_BITS = 11
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              sample_valid,
    input  logic              sample_stall,
    input  logic [RAW_W-1:0]  adc_sample,

    input  logic              result_valid,
    input  logic              result_stall,
    input  code_t             key_event,
    input  code_t             current_key,

    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0] cfg_data,

    output int                fail_count,
    output int                outstanding,
    output int                results_checked,
    output int                press_downs,
    output int                long_downs,
    output int                releases
);

    typedef struct packed {
        code_t ev;
        code_t key;
    } key_report_t;

    key_report_t            pending_reports[$];
    cfg_t                   regs;
    logic                   key_held;
    code_t                  held_key;
    logic [COUNT_BITS-1:0]  hold_cnt;

    // first band whose (lower, upper] range holds the voltage, none otherwise
    function automatic code_t band_of(input int unsigned mv);
        int unsigned bounds [5];
        code_t       found;
        int          k;
        bounds[0] = 32'(regs.release_level);
        bounds[1] = 32'(regs.band_one_top);
        bounds[2] = 32'(regs.band_two_top);
        bounds[3] = 32'(regs.band_three_top);
        bounds[4] = 32'(regs.band_four_top);
        found = KEY_NONE;
        for (k = 0; k < 4; k++)
            if (found == KEY_NONE && mv > bounds[k] && mv <= bounds[k+1])
                found = code_t'(k + 1);
        return found;
    endfunction

    task automatic decode_sample(input logic [RAW_W-1:0] raw, output key_report_t rep);
        int unsigned mv;
        code_t       key;
        mv = 32'(raw);
        mv = mv * MV_FULL / RAW_FULL;
        rep.ev = EV_NONE;
        if (mv <= 32'(regs.release_level)) begin
            if (key_held) begin
                rep.ev = (32'(hold_cnt) < 32'(regs.long_press_samples)) ? EV_UP : EV_LONG_UP;
                key_held = 1'b0;
            end
        end
        else begin
            key = band_of(mv);
            if (!key_held) begin
                hold_cnt = '0;
                if (key != KEY_NONE)
                    held_key = key;
            end
            if (held_key != key) begin
                hold_cnt = '0;
                held_key = key;
            end
            else begin
                hold_cnt = hold_cnt + COUNT_BITS'(1);
                if (32'(hold_cnt) == 32'(regs.long_press_samples))
                    rep.ev = EV_LONG_DOWN;
                else if (32'(hold_cnt) == 32'(regs.debounce_samples))
                    rep.ev = EV_DOWN;
                else if (32'(hold_cnt) > 32'(regs.long_press_samples))
                    hold_cnt = COUNT_BITS'(32'(regs.long_press_samples) + 1);
            end
            key_held = 1'b1;
        end
        rep.key = held_key;
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    always @(posedge clk) begin : watch
        key_report_t want;
        if (!rst_n) begin
            regs.release_level      = RST_RELEASE_LEVEL;
            regs.band_one_top       = RST_BAND_ONE_TOP;
            regs.band_two_top       = RST_BAND_TWO_TOP;
            regs.band_three_top     = RST_BAND_THREE_TOP;
            regs.band_four_top      = RST_BAND_FOUR_TOP;
            regs.debounce_samples   = RST_DEBOUNCE;
            regs.long_press_samples = RST_LONG_PRESS;
            key_held = 1'b0;
            held_key = KEY_NONE;
            hold_cnt = '0;
            pending_reports.delete();
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RELEASE_LEVEL:  regs.release_level      = cfg_data[MV_W-1:0];
                    REG_BAND_ONE_TOP:   regs.band_one_top       = cfg_data[MV_W-1:0];
                    REG_BAND_TWO_TOP:   regs.band_two_top       = cfg_data[MV_W-1:0];
                    REG_BAND_THREE_TOP: regs.band_three_top     = cfg_data[MV_W-1:0];
                    REG_BAND_FOUR_TOP:  regs.band_four_top      = cfg_data[MV_W-1:0];
                    REG_DEBOUNCE:       regs.debounce_samples   = cfg_data[SAMPLES_W-1:0];
                    REG_LONG_PRESS:     regs.long_press_samples = cfg_data[SAMPLES_W-1:0];
                    default: ;
                endcase
            end

            if (sample_valid && !sample_stall) begin
                decode_sample(adc_sample, want);
                pending_reports.push_back(want);
                case (want.ev)
                    EV_DOWN:               press_downs++;
                    EV_LONG_DOWN:          long_downs++;
                    EV_UP, EV_LONG_UP:     releases++;
                    default: ;
                endcase
            end

            if (result_valid && !result_stall) begin
                if (pending_reports.size() == 0)
                    note_failure($sformatf("unexpected result: event %0d key %0d",
                                           key_event, current_key));
                else begin
                    want = pending_reports.pop_front();
                    results_checked++;
                    if (key_event !== want.ev || current_key !== want.key)
                        note_failure($sformatf(
                            "result %0d mismatch: event exp %0d got %0d, key exp %0d got %0d",
                            results_checked, want.ev, key_event, want.key, current_key));
                end
            end
        end
        outstanding = pending_reports.size();
    end

endmodule

@@ tb/tb_resistor_ladder_key_decoder.sv @@
// tb_resistor_ladder_key_decoder: drives samples, register writes and result stalls into the
// ladder key decoder; rlkd_checker beside it predicts and compares every result
// depends on rlkd_pkg, rlkd_checker and resistor_ladder_key_decoder

module tb_resistor_ladder_key_decoder;
    import rlkd_pkg::*;

    localparam int COUNT_BITS   = 11;
    localparam int IDLE_LIMIT   = 2000;   // cycles with no handshake at all
    localparam int RANDOM_ITEMS = 400;
    localparam int NUM_PHASES   = 14;     // phase 0 runs on reset values
    localparam int TAIL_CYCLES  = 4;      // margin after the last result

    // index that no register answers to
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

    // full-scale voltage as a register value
    localparam mv_t MV_TOP = MV_W'(MV_FULL);

    logic              clk;
    logic              rst_n        = 1'b0;
    logic              sample_valid = 1'b0;
    logic              sample_stall;
    logic [RAW_W-1:0]  adc_sample   = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    code_t             key_event;
    code_t             current_key;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index    = '0;
    logic [DATA_W-1:0] cfg_data     = '0;

    int fail_count;
    int outstanding;
    int results_checked;
    int press_downs;
    int long_downs;
    int releases;

    // stimulus bookkeeping: the ladder currently programmed and what has gone in
    cfg_t        setting;
    bit          no_gaps;
    int          samples_sent;
    int          settings_loaded;
    int          idle_cycles;
    int unsigned stall_left;

    resistor_ladder_key_decoder #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .adc_sample   (adc_sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .key_event    (key_event),
        .current_key  (current_key),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    rlkd_checker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .adc_sample      (adc_sample),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .key_event       (key_event),
        .current_key     (current_key),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .press_downs     (press_downs),
        .long_downs      (long_downs),
        .releases        (releases)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog: any accepted item, result or register write restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // result side back-pressure: runs of stall and no stall of random length,
    // mostly short, a few long, and some quiet stretches with no stall at all
    always @(posedge clk)
    begin : stall_gen
        int r;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left == 0)
        begin
            r = $urandom_range(99);
            if (r < 40)
            begin
                result_stall <= 1'b0;
                stall_left   <= $urandom_range(5, 1) - 1;
            end
            else if (r < 55)
            begin
                result_stall <= 1'b0;
                stall_left   <= $urandom_range(80, 20) - 1;
            end
            else if (r < 85)
            begin
                result_stall <= 1'b1;
                stall_left   <= $urandom_range(3, 1) - 1;
            end
            else if (r < 96)
            begin
                result_stall <= 1'b1;
                stall_left   <= $urandom_range(12, 4) - 1;
            end
            else
            begin
                result_stall <= 1'b1;
                stall_left   <= $urandom_range(40, 20) - 1;
            end
        end
        else
            stall_left <= stall_left - 1;
    end

    // smallest raw reading that converts to at least mv millivolts
    function automatic int raw_for(input int mv);
        return (mv * RAW_FULL + MV_FULL - 1) / MV_FULL;
    endfunction

    // sender gap after an item: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(3, 1);
        else if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    // any reading whose voltage falls in the band of key k under the current ladder;
    // key none means above the top band; an empty band gets a random reading
    function automatic logic [RAW_W-1:0] raw_in_band(input code_t k);
        int lo;
        int hi;
        int raw_lo;
        int raw_hi;
        case (k)
            KEY_RECORD:
            begin
                lo = int'(setting.release_level);
                hi = int'(setting.band_one_top);
            end
            KEY_NEXT:
            begin
                lo = int'(setting.band_one_top);
                hi = int'(setting.band_two_top);
            end
            KEY_PREVIOUS:
            begin
                lo = int'(setting.band_two_top);
                hi = int'(setting.band_three_top);
            end
            KEY_PLAY:
            begin
                lo = int'(setting.band_three_top);
                hi = int'(setting.band_four_top);
            end
            default:
            begin
                lo = int'(setting.band_four_top);
                hi = MV_FULL;
            end
        endcase
        // stay above the release level so the reading counts as a press
        if (lo < int'(setting.release_level))
            lo = int'(setting.release_level);
        if (hi <= lo)
            return RAW_W'($urandom_range(RAW_FULL, 0));
        raw_lo = raw_for(lo + 1);
        raw_hi = raw_for(hi + 1) - 1;
        if (raw_hi > RAW_FULL)
            raw_hi = RAW_FULL;
        return RAW_W'($urandom_range(raw_hi, raw_lo));
    endfunction

    function automatic logic [RAW_W-1:0] raw_released();
        int raw_hi;
        raw_hi = raw_for(int'(setting.release_level) + 1) - 1;
        if (raw_hi > RAW_FULL)
            raw_hi = RAW_FULL;
        return RAW_W'($urandom_range(raw_hi, 0));
    endfunction

    function automatic code_t pick_key();
        if ($urandom_range(9) == 0)
            return KEY_NONE;
        return code_t'($urandom_range(KEY_PLAY, KEY_RECORD));
    endfunction

    // ladder settings per phase: special corners first, then random ordered ladders
    function automatic cfg_t make_setting(input int ph);
        cfg_t        s;
        int unsigned cut [5];
        int unsigned t;
        int          i;
        int          j;
        for (i = 0; i < 5; i++)
            cut[i] = $urandom_range(MV_FULL, 0);
        for (i = 0; i < 4; i++)
            for (j = 0; j < 4 - i; j++)
                if (cut[j] > cut[j+1])
                begin
                    t        = cut[j];
                    cut[j]   = cut[j+1];
                    cut[j+1] = t;
                end
        s.release_level      = MV_W'(cut[0]);
        s.band_one_top       = MV_W'(cut[1]);
        s.band_two_top       = MV_W'(cut[2]);
        s.band_three_top     = MV_W'(cut[3]);
        s.band_four_top      = MV_W'(cut[4]);
        s.debounce_samples   = SAMPLES_W'($urandom_range(6, 1));
        s.long_press_samples = SAMPLES_W'($urandom_range(30, int'(s.debounce_samples) + 1));
        case (ph)
            1:
            begin
                // everything above zero is the record key; both counts at one
                s = '{release_level: 0, band_one_top: MV_TOP, band_two_top: MV_TOP,
                      band_three_top: MV_TOP, band_four_top: MV_TOP,
                      debounce_samples: 1, long_press_samples: 1};
            end
            2:
            begin
                // nothing ever counts as pressed; counts at their maximum
                s = '{release_level: MV_TOP, band_one_top: MV_TOP, band_two_top: MV_TOP,
                      band_three_top: MV_TOP, band_four_top: MV_TOP,
                      debounce_samples: 1023, long_press_samples: 1023};
            end
            3:
            begin
                // badly ordered bands with a zero debounce count
                s = '{release_level: 1200, band_one_top: 800, band_two_top: 1600,
                      band_three_top: 1400, band_four_top: 2000,
                      debounce_samples: 0, long_press_samples: 5};
            end
            4:
            begin
                // debounce count above the long-press count
                s.debounce_samples   = 8;
                s.long_press_samples = 3;
            end
            5:
            begin
                // zero long-press count
                s.debounce_samples   = 2;
                s.long_press_samples = 0;
            end
            6:
            begin
                // long-press count far above the random ones, reached once by a full hold
                s.debounce_samples   = 50;
                s.long_press_samples = 80;
            end
            7:
            begin
                s = '{release_level: RST_RELEASE_LEVEL, band_one_top: RST_BAND_ONE_TOP,
                      band_two_top: RST_BAND_TWO_TOP, band_three_top: RST_BAND_THREE_TOP,
                      band_four_top: RST_BAND_FOUR_TOP, debounce_samples: RST_DEBOUNCE,
                      long_press_samples: RST_LONG_PRESS};
            end
            default: ;
        endcase
        return s;
    endfunction

    // present one item, hold it until accepted, then maybe leave a gap
    task automatic send_sample(input logic [RAW_W-1:0] raw);
        int gap;
        sample_valid <= 1'b1;
        adc_sample   <= raw;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        samples_sent++;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending until every expected result is out, then let the pipeline settle
    task automatic drain();
        sample_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // program a whole ladder while idle; a write to the unused index goes along
    task automatic load_setting(input cfg_t s);
        drain();
        write_reg(REG_RELEASE_LEVEL, s.release_level);
        write_reg(REG_BAND_ONE_TOP, s.band_one_top);
        write_reg(REG_BAND_TWO_TOP, s.band_two_top);
        write_reg(REG_UNUSED, DATA_W'($urandom_range(4095, 0)));
        write_reg(REG_BAND_THREE_TOP, s.band_three_top);
        write_reg(REG_BAND_FOUR_TOP, s.band_four_top);
        write_reg(REG_DEBOUNCE, DATA_W'(s.debounce_samples));
        write_reg(REG_LONG_PRESS, DATA_W'(s.long_press_samples));
        cfg_valid <= 1'b0;
        repeat (2) @(posedge clk);
        setting = s;
        settings_loaded++;
    endtask

    // hold a key for a number of items, now and then sliding to another key,
    // then let go for a few items
    task automatic press_key(input code_t k, input int hold);
        int i;
        int let_go;
        for (i = 0; i < hold; i++)
        begin
            if ($urandom_range(19) == 0)
                k = pick_key();
            send_sample(raw_in_band(k));
        end
        let_go = $urandom_range(3, 1);
        for (i = 0; i < let_go; i++)
            send_sample(raw_released());
    endtask

    // hold lengths aimed around the debounce and long-press counts,
    // capped so that a huge count does not swamp the item budget
    function automatic int pick_hold();
        int deb;
        int lng;
        int h;
        deb = int'(setting.debounce_samples);
        lng = int'(setting.long_press_samples);
        case ($urandom_range(3))
            0:       h = $urandom_range(deb + 1, 1);
            1:       h = $urandom_range(deb + 2, deb);
            2:       h = (lng <= 40) ? $urandom_range(lng + 3, lng > 0 ? lng - 1 : 0)
                                     : $urandom_range(4, 1);
            default: h = $urandom_range(10, 1);
        endcase
        if (h > 48)
            h = 48;
        return (h < 1) ? 1 : h;
    endfunction

    // mostly well-formed presses with random content, some raw noise,
    // and now and then a full pause until the block is empty
    task automatic run_phase(input int budget);
        int start;
        int r;
        start = samples_sent;
        // one hold past the long-press count whenever some band can be hit
        if (setting.release_level < setting.band_four_top)
            press_key(pick_key(), int'(setting.long_press_samples) + 2);
        while (samples_sent - start < budget)
        begin
            r = $urandom_range(99);
            if (r < 70)
                press_key(pick_key(), pick_hold());
            else if (r < 96)
                send_sample(RAW_W'($urandom_range(RAW_FULL, 0)));
            else
                drain();
        end
    endtask

    initial
    begin : stimulus
        int ph;
        setting = make_setting(7);
        no_gaps = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on reset values: release with nothing held, key none
        // pressed from idle, exact band edges, key changes, release into none
        send_sample('0);
        send_sample(RAW_W'(RAW_FULL));
        send_sample(RAW_W'(RAW_FULL));         // press-down for key none
        send_sample(RAW_W'(raw_for(500)));     // exactly at release level
        send_sample(RAW_W'(raw_for(501)));     // record, lower edge
        send_sample(RAW_W'(raw_for(900)));     // record, upper edge
        send_sample(RAW_W'(raw_for(901)));     // change to next
        send_sample(RAW_W'(raw_for(1150)));
        send_sample(RAW_W'(raw_for(1151)));    // change to previous
        send_sample(RAW_W'(raw_for(1500)));
        send_sample(RAW_W'(raw_for(1501)));    // change to play
        send_sample(RAW_W'(raw_for(1900)));
        send_sample(RAW_W'(raw_for(1901)));    // above the top band
        send_sample(RAW_W'(RAW_FULL));
        send_sample('0);
        send_sample(RAW_W'(raw_for(1700)));    // fresh press on play
        send_sample('0);
        send_sample(RAW_W'(raw_for(1901)));    // fresh press above the top band
        send_sample(12'hAAA);
        send_sample(12'h555);
        send_sample(12'hFFF);
        send_sample(12'h800);
        send_sample(12'h7FF);
        send_sample('0);

        for (ph = 1; ph < NUM_PHASES; ph++)
        begin
            load_setting(make_setting(ph));
            no_gaps = ($urandom_range(3) == 0);
            run_phase(RANDOM_ITEMS / (NUM_PHASES - 1));
        end

        drain();
        $display("covered %0d samples under %0d ladder settings, %0d results compared",
                 samples_sent, settings_loaded + 1, results_checked);
        $display("expected events: %0d press-down, %0d long-down, %0d key releases",
                 press_downs, long_downs, releases);
        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
        begin
            if (outstanding != 0)
                $display("%0d expected results never arrived", outstanding);
            $display("status: fail");
        end
        $finish;
    end

endmodule
